@@ hdl/itoa_pkg.sv @@
// Shared constants, widths and the digit-to-ASCII mapping for the
// integer to ASCII converter. No dependencies.
package itoa_pkg;

  localparam int unsigned NUMBER_WIDTH_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned DIV_STEPS        = 8;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] NULL_CHAR  = 7'h00;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CHAR = 7'h61;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d inside {[6'd0:6'd9]}) begin
      g = ZERO_CHAR + {1'b0, d};
    end else if (d < RADIX_MAX) begin
      g = ALPHA_CHAR + {1'b0, d} - 7'd10;
    end else begin
      g = ZERO_CHAR;
    end
    return g;
  endfunction

endpackage

@@ hdl/itoa_stream_if.sv @@
// Valid/ready stream interfaces for the converter: integers in, characters out.
// Depends on itoa_pkg.
interface itoa_num_if import itoa_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface itoa_chr_if import itoa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;
  logic              bad_base;

  modport source (output valid, output character, output last_char, output bad_base,
                  input ready);
  modport sink   (input valid, input character, input last_char, input bad_base,
                  output ready);
endinterface

@@ hdl/integer_to_ascii_radix.sv @@
// Integer to ASCII text converter, bases 2 to 36. Each number goes into the queue,
// then the radix divider forms its digits, least significant first, in the digit memory,
// then '-' for a negative number and each character via the memory's registered read.
// A bad radix gives one NUL output with bad_base and last_char set. The back takes a new
// number only when idle; the front accepts while the back works.
// Reset is asynchronous active low: radix 10, queue empty; the digit memory is not cleared.
module integer_to_ascii_radix import itoa_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS   = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,
  itoa_num_if.sink           num_i,
  itoa_chr_if.source         chr_o
);

  localparam int unsigned CMD_W = 2 + RADIX_W + NUMBER_WIDTH;

  logic             push_valid, push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [CMD_W-1:0] pop_data;

  itoa_front #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .CMD_W        (CMD_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .num_i        (num_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  itoa_queue #(
    .DATA_W (CMD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  itoa_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .MAX_DIGITS   (MAX_DIGITS),
    .CMD_W        (CMD_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .chr_o       (chr_o)
  );

endmodule

@@ hdl/itoa_queue.sv @@
// Short command queue between the classify front end and the conversion back end.
// Depends on itoa_pkg.
module itoa_queue import itoa_pkg::*; #(
  parameter int unsigned DATA_W = 40,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/itoa_front.sv @@
// Front end: holds the radix register, accepts integers, forms sign, magnitude
// and the bad-radix flag, and pushes one command per transaction. Depends on itoa_pkg.
module itoa_front import itoa_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int unsigned CMD_W        = 2 + RADIX_W + NUMBER_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,
  itoa_num_if.sink           num_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output logic [CMD_W-1:0]   push_data_o
);

  typedef struct packed {
    logic                    bad;
    logic                    neg;
    logic [RADIX_W-1:0]      radix;
    logic [NUMBER_WIDTH-1:0] mag;
  } cmd_t;

  logic [RADIX_W-1:0]      radix_q;
  logic [NUMBER_WIDTH-1:0] raw;
  cmd_t                    cmd;

  assign raw          = num_i.number;
  assign num_i.ready  = push_ready_i;
  assign push_valid_o = num_i.valid;

  always_comb begin
    cmd.neg   = raw[NUMBER_WIDTH-1];
    cmd.mag   = cmd.neg ? (~raw + 1'b1) : raw;
    cmd.radix = radix_q;
    cmd.bad   = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
  end

  assign push_data_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

endmodule

@@ hdl/itoa_back.sv @@
// Back end: divides the magnitude by the radix, DIV_STEPS quotient bits a cycle,
// stores the digits and emits sign and characters most significant first, or a bad_base flag.
// Depends on itoa_pkg and itoa_stream_if.
module itoa_back import itoa_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS   = MAX_DIGITS_DEF,
  parameter int unsigned CMD_W        = 2 + RADIX_W + NUMBER_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  logic [CMD_W-1:0] pop_data_i,
  itoa_chr_if.source       chr_o
);

  localparam int unsigned DIV_CYCLES = (NUMBER_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned PAD_W      = DIV_CYCLES * DIV_STEPS;
  localparam int unsigned STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  typedef struct packed {
    logic                    bad;
    logic                    neg;
    logic [RADIX_W-1:0]      radix;
    logic [NUMBER_WIDTH-1:0] mag;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_SIGN,
    B_READ,
    B_CHAR,
    B_BAD
  } state_e;

  state_e             state_q;
  cmd_t               cmd;
  logic [PAD_W-1:0]   quo_q, div_quo;
  logic [DIGIT_W:0]   rem_q, div_rem;
  logic [RADIX_W-1:0] rad_q;
  logic               neg_q;
  logic [STEP_W-1:0]  step_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [DIGIT_W-1:0] rd_data_q;
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic               digit_end;
  logic               digit_we;

  assign cmd         = pop_data_i;
  assign pop_ready_o = (state_q == B_IDLE);
  assign digit_end   = (step_q == STEP_W'(DIV_CYCLES - 1));
  assign digit_we    = (state_q == B_DIV) && digit_end;

  always_comb begin
    logic [DIGIT_W:0] r;
    logic [PAD_W-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[DIGIT_W-1:0], q[PAD_W-1]};
      q = {q[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, rad_q}) begin
        r    = r - {1'b0, rad_q};
        q[0] = 1'b1;
      end
    end
    div_rem = r;
    div_quo = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cnt_q    <= '0;
      step_q   <= '0;
      rd_idx_q <= '0;
      neg_q    <= 1'b0;
      rad_q    <= RADIX_RESET;
      rem_q    <= '0;
      quo_q    <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            cnt_q <= '0;
            if (cmd.bad) begin
              state_q <= B_BAD;
            end else begin
              quo_q   <= PAD_W'(cmd.mag);
              rem_q   <= '0;
              rad_q   <= cmd.radix;
              neg_q   <= cmd.neg;
              step_q  <= '0;
              state_q <= B_DIV;
            end
          end
        end
        B_DIV: begin
          quo_q <= div_quo;
          if (digit_end) begin
            step_q <= '0;
            rem_q  <= '0;
            cnt_q  <= cnt_q + 1'b1;
            if ((div_quo == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1))) begin
              rd_idx_q <= cnt_q[IDX_W-1:0];
              state_q  <= neg_q ? B_SIGN : B_READ;
            end
          end else begin
            rem_q  <= div_rem;
            step_q <= step_q + 1'b1;
          end
        end
        B_SIGN: begin
          if (chr_o.ready) begin
            state_q <= B_READ;
          end
        end
        B_READ: begin
          state_q <= B_CHAR;
        end
        B_CHAR: begin
          if (chr_o.ready) begin
            if (rd_idx_q == '0) begin
              state_q <= B_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q - 1'b1;
              state_q  <= B_READ;
            end
          end
        end
        B_BAD: begin
          if (chr_o.ready) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (digit_we) begin
      digit_mem[cnt_q[IDX_W-1:0]] <= div_rem[DIGIT_W-1:0];
    end
    rd_data_q <= digit_mem[rd_idx_q];
  end

  always_comb begin
    chr_o.valid     = 1'b0;
    chr_o.character = NULL_CHAR;
    chr_o.last_char = 1'b0;
    chr_o.bad_base  = 1'b0;
    case (state_q)
      B_SIGN: begin
        chr_o.valid     = 1'b1;
        chr_o.character = MINUS_CHAR;
      end
      B_CHAR: begin
        chr_o.valid     = 1'b1;
        chr_o.character = digit_glyph(rd_data_q);
        chr_o.last_char = (rd_idx_q == '0);
      end
      B_BAD: begin
        chr_o.valid     = 1'b1;
        chr_o.last_char = 1'b1;
        chr_o.bad_base  = 1'b1;
      end
      default: begin
        chr_o.valid = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> (rad_q >= RADIX_MIN) && (rad_q <= RADIX_MAX))
    else $error("division running with a radix outside the legal range");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> rem_q < {1'b0, rad_q})
    else $error("partial remainder not below the radix");

  a_idx_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ || state_q == B_CHAR) |-> CNT_W'(rd_idx_q) < cnt_q)
    else $error("digit read beyond the digits stored for this number");

  a_bad_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_BAD && chr_o.ready) |=> state_q == B_IDLE && cnt_q == '0)
    else $error("bad radix result not followed by idle with cleared count");
`endif

endmodule
